// ===== rtl/pulse_energy_meter_macros.svh =====
// ----------------------------------------------------------------------------
// pulse energy meter assertion macros
// shared property forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PULSE_ENERGY_METER_MACROS_SVH
`define PULSE_ENERGY_METER_MACROS_SVH

// same-cycle implication
`define PEM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PEM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pem_pkg
// shared constants, register codes and types of the pulse energy meter
// ----------------------------------------------------------------------------
package pem_pkg;

  localparam int ENERGY_WIDTH_DEF = 48;
  localparam int WINDOW_WIDTH_DEF = 32;
  localparam int CFG_W            = 48;
  localparam int IDX_W            = 3;
  localparam int CNT_W            = 7;

  typedef enum logic [IDX_W-1:0] {
    REG_INTEG       = 3'd0,
    REG_POWER_GAIN  = 3'd1,
    REG_VOLT_GAIN   = 3'd2,
    REG_CURR_GAIN   = 3'd3,
    REG_SAVE_DELTA  = 3'd4,
    REG_SAVE_TICKS  = 3'd5,
    REG_RESTORE     = 3'd6
  } cfg_reg_t;

  localparam logic [7:0]  INTEG_RST      = 8'd20;
  localparam logic [19:0] POWER_GAIN_RST = 20'd45004;
  localparam logic [19:0] VOLT_GAIN_RST  = 20'd34176;
  localparam logic [19:0] CURR_GAIN_RST  = 20'd75357;
  localparam logic [31:0] SAVE_DELTA_RST = 32'd80000;
  localparam logic [16:0] SAVE_TICKS_RST = 17'd86400;

  localparam logic [16:0] TSS_MAX   = 17'h1FFFF;
  localparam logic [17:0] K_SCALE10 = 18'd156250;  // 15625 * 10
  localparam logic [17:0] K_SCALE1  = 18'd15625;
  localparam logic [17:0] DEN_K     = 18'd160000;  // 16 * 10000
  localparam logic [19:0] GAIN_FREQ = 20'd10000;
  localparam logic [25:0] WH_DIV    = 26'd36000000;
  localparam logic [41:0] WH_MAX    = {42{1'b1}};

  typedef enum logic {OP_MUL, OP_DIV} eng_op_t;

  typedef struct packed {
    logic             start;
    eng_op_t          op;
    logic [CNT_W-1:0] cnt;
  } eng_ctl_t;

  typedef struct packed {
    logic [14:0] power_dw;
    logic [15:0] voltage_dv;
    logic [15:0] current_ma;
    logic [15:0] power_freq_dhz;
    logic [41:0] energy_wh;
  } conv_res_t;

endpackage
`default_nettype wire

// ===== rtl/pem_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pem_serial
// bit-serial shift-add multiplier and shift-subtract divider
// ----------------------------------------------------------------------------
module pem_serial
  import pem_pkg::*;
#(
  parameter int DSH_W = 66
) (
  input  logic             clk,
  input  logic             rst,
  input  eng_ctl_t         ctl,
  input  logic [63:0]      opa,
  input  logic [DSH_W-1:0] opb,
  output logic [63:0]      res,
  output logic [63:0]      rem,
  output logic             done
);

  logic             busy;
  eng_op_t          op;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      wrk;
  logic [DSH_W-1:0] sh;
  logic             ge;

  // div: aligned divisor fits under the remainder
  assign ge  = DSH_W'(wrk) >= sh;
  assign rem = wrk;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        cnt  <= ctl.cnt;
        res  <= '0;
        wrk  <= opa;
        sh   <= opb;
      end else if (busy) begin
        unique case (op)
          OP_MUL: begin
            if (sh[0]) res <= res + wrk;
            wrk <= wrk << 1;
          end
          OP_DIV: begin
            if (ge) wrk <= wrk - sh[63:0];
            res <= {res[62:0], ge};
          end
          default: ;
        endcase
        sh  <= sh >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pem_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pem_accum
// configuration registers, tick deltas, windows, energy total and save logic
// ----------------------------------------------------------------------------
module pem_accum
  import pem_pkg::*;
#(
  parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF,
  parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [IDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        accept,
  input  logic [15:0]                 power_pulse_count,
  input  logic [15:0]                 mode_pulse_count,
  input  logic [15:0]                 timebase_count,
  output logic [2:0][WINDOW_WIDTH-1:0] pub_pulses,
  output logic [2:0][WINDOW_WIDTH-1:0] pub_ticks,
  output logic [ENERGY_WIDTH-1:0]     energy,
  output logic [19:0]                 power_gain,
  output logic [19:0]                 voltage_gain,
  output logic [19:0]                 current_gain,
  output logic                        save_now,
  output logic [47:0]                 save_value,
  output logic                        mode
);

  localparam int WW = WINDOW_WIDTH;
  localparam int EW = ENERGY_WIDTH;

  logic [7:0]    integ;
  logic [31:0]   save_delta;
  logic [16:0]   save_ticks;
  logic          baseline;
  logic [15:0]   last_power, last_mode, last_tb;
  logic [WW-1:0] pw_p, pw_t, mw_p, mw_t;
  logic [7:0]    wtc;
  logic [EW-1:0] last_saved;
  logic [16:0]   tss;
  logic          settle;

  logic [15:0]   pd, md, td;
  logic [EW-1:0] energy_sum, unsaved;
  logic [16:0]   tss_inc;
  logic          save_hit;
  logic [7:0]    wtc_inc;
  logic          publish;
  logic [WW-1:0] pw_p_sum, pw_t_sum, mw_p_new, mw_t_new;
  logic [63:0]   energy64, restore64;

  always_comb begin
    pd         = power_pulse_count - last_power;
    md         = mode_pulse_count - last_mode;
    td         = timebase_count - last_tb;
    energy_sum = energy + EW'(pd);
    tss_inc    = (tss != TSS_MAX) ? tss + 17'd1 : tss;
    unsaved    = energy_sum - last_saved;
    save_hit   = (unsaved >= EW'(save_delta)) ||
                 ((energy_sum != last_saved) && (tss_inc >= save_ticks));
    wtc_inc    = wtc + 8'd1;
    publish    = wtc_inc >= integ;
    pw_p_sum   = pw_p + WW'(pd);
    pw_t_sum   = pw_t + WW'(td);
    mw_p_new   = settle ? mw_p : mw_p + WW'(md);
    mw_t_new   = settle ? mw_t : mw_t + WW'(td);
    energy64   = 64'(energy_sum);
    restore64  = 64'(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ        <= INTEG_RST;
      power_gain   <= POWER_GAIN_RST;
      voltage_gain <= VOLT_GAIN_RST;
      current_gain <= CURR_GAIN_RST;
      save_delta   <= SAVE_DELTA_RST;
      save_ticks   <= SAVE_TICKS_RST;
      baseline     <= 1'b0;
      last_power   <= '0;
      last_mode    <= '0;
      last_tb      <= '0;
      pw_p         <= '0;
      pw_t         <= '0;
      mw_p         <= '0;
      mw_t         <= '0;
      wtc          <= '0;
      pub_pulses   <= '0;
      pub_ticks    <= '0;
      energy       <= '0;
      last_saved   <= '0;
      tss          <= '0;
      mode         <= 1'b0;
      settle       <= 1'b0;
      save_now     <= 1'b0;
      save_value   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_INTEG:      integ        <= cfg_data[7:0];
          REG_POWER_GAIN: power_gain   <= cfg_data[19:0];
          REG_VOLT_GAIN:  voltage_gain <= cfg_data[19:0];
          REG_CURR_GAIN:  current_gain <= cfg_data[19:0];
          REG_SAVE_DELTA: save_delta   <= cfg_data[31:0];
          REG_SAVE_TICKS: save_ticks   <= cfg_data[16:0];
          REG_RESTORE: begin
            energy     <= restore64[EW-1:0];
            last_saved <= restore64[EW-1:0];
          end
          default: ;
        endcase
      end
      if (accept) begin
        save_now   <= 1'b0;
        save_value <= '0;
        if (!baseline) begin
          baseline <= 1'b1;
        end else begin
          energy <= energy_sum;
          pw_p   <= pw_p_sum;
          pw_t   <= pw_t_sum;
          mw_p   <= mw_p_new;
          mw_t   <= mw_t_new;
          settle <= 1'b0;
          wtc    <= wtc_inc;
          if (save_hit) begin
            save_now   <= 1'b1;
            save_value <= energy64[47:0];
            last_saved <= energy_sum;
            tss        <= '0;
          end else begin
            tss <= tss_inc;
          end
          if (publish) begin
            pub_pulses[0] <= pw_p_sum;
            pub_ticks[0]  <= pw_t_sum;
            if (mode) begin
              pub_pulses[2] <= mw_p_new;
              pub_ticks[2]  <= mw_t_new;
            end else begin
              pub_pulses[1] <= mw_p_new;
              pub_ticks[1]  <= mw_t_new;
            end
            pw_p   <= '0;
            pw_t   <= '0;
            mw_p   <= '0;
            mw_t   <= '0;
            wtc    <= '0;
            mode   <= ~mode;
            settle <= 1'b1;
          end
        end
        last_power <= power_pulse_count;
        last_mode  <= mode_pulse_count;
        last_tb    <= timebase_count;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pem_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pem_calc
// conversion sequencer: scaled window values and watt-hours on the serial unit
// ----------------------------------------------------------------------------
module pem_calc
  import pem_pkg::*;
#(
  parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF,
  parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF,
  parameter int DSH_W        = 66
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         take,
  input  logic [2:0][WINDOW_WIDTH-1:0] pub_pulses,
  input  logic [2:0][WINDOW_WIDTH-1:0] pub_ticks,
  input  logic [ENERGY_WIDTH-1:0]      energy,
  input  logic [19:0]                  power_gain,
  input  logic [19:0]                  voltage_gain,
  input  logic [19:0]                  current_gain,
  output logic                         busy,
  output logic                         res_valid,
  output conv_res_t                    results
);

  localparam int WW      = WINDOW_WIDTH;
  localparam int Q_W     = ENERGY_WIDTH - 25;
  localparam int E_SHIFT = ENERGY_WIDTH - 26;
  localparam logic [CNT_W-1:0] E_CNT   = CNT_W'(ENERGY_WIDTH - 25);
  localparam logic [CNT_W-1:0] W_CNT   = CNT_W'(WINDOW_WIDTH);
  localparam logic [CNT_W-1:0] G_CNT   = CNT_W'(20);
  localparam logic [CNT_W-1:0] CNT_16  = CNT_W'(16);
  localparam logic [CNT_W-1:0] CNT_17  = CNT_W'(17);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SMUL, S_SDIV, S_EDIV, S_EMUL, S_EDIV2, S_DONE
  } state_t;

  typedef enum logic [1:0] {CV_POWER, CV_VOLT, CV_CURR, CV_FREQ} conv_t;

  state_t         state;
  conv_t          sel;
  logic           go;
  logic [37:0]    kreg;
  logic [WW+17:0] den;
  logic [Q_W-1:0] eq;
  logic [25:0]    er;
  logic [45:0]    rprod;
  logic [63:0]    ewh;

  logic [1:0]       slot;
  logic [19:0]      gain_sel;
  logic [17:0]      kconst;
  logic             sat15;
  logic [WW-1:0]    pulses_sel, ticks_sel;
  eng_ctl_t         ctl;
  logic [63:0]      opa;
  logic [DSH_W-1:0] opb;
  logic [63:0]      eng_res, eng_rem;
  logic             eng_done;
  logic             qsat;
  logic [15:0]      qval;
  logic [63:0]      wh_sum;

  always_comb begin
    unique case (sel)
      CV_POWER: begin slot = 2'd0; gain_sel = power_gain;   kconst = K_SCALE10; end
      CV_VOLT:  begin slot = 2'd1; gain_sel = voltage_gain; kconst = K_SCALE1;  end
      CV_CURR:  begin slot = 2'd2; gain_sel = current_gain; kconst = K_SCALE1;  end
      CV_FREQ:  begin slot = 2'd0; gain_sel = GAIN_FREQ;    kconst = K_SCALE10; end
      default:  begin slot = 2'd0; gain_sel = GAIN_FREQ;    kconst = K_SCALE10; end
    endcase
    sat15      = (sel == CV_POWER);
    pulses_sel = pub_pulses[slot];
    ticks_sel  = pub_ticks[slot];

    // quotient top bit flags a value past the cap
    qsat = sat15 ? eng_res[15] : eng_res[16];
    if (sat15) qval = qsat ? 16'h7FFF : {1'b0, eng_res[14:0]};
    else       qval = qsat ? 16'hFFFF : eng_res[15:0];

    wh_sum = ewh + eng_res;

    ctl.start = go;
    unique case (state)
      S_SMUL: begin
        ctl.op = OP_MUL; ctl.cnt = W_CNT;
        opa = 64'(kreg); opb = DSH_W'(pulses_sel);
      end
      S_SDIV: begin
        ctl.op  = OP_DIV;
        ctl.cnt = sat15 ? CNT_16 : CNT_17;
        opa     = eng_res;
        opb     = sat15 ? (DSH_W'(den) << 15) : (DSH_W'(den) << 16);
      end
      S_EDIV: begin
        ctl.op = OP_DIV; ctl.cnt = E_CNT;
        opa = 64'(energy); opb = DSH_W'(WH_DIV) << E_SHIFT;
      end
      S_EMUL: begin
        ctl.op = OP_MUL; ctl.cnt = G_CNT;
        opa = 64'(eq); opb = DSH_W'(power_gain);
      end
      S_EDIV2: begin
        ctl.op = OP_DIV; ctl.cnt = G_CNT;
        opa = 64'(rprod); opb = DSH_W'(WH_DIV) << 19;
      end
      default: begin
        ctl.op = OP_MUL; ctl.cnt = G_CNT;
        opa = '0; opb = '0;
      end
    endcase
  end

  pem_serial #(.DSH_W(DSH_W)) u_serial (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .opa  (opa),
    .opb  (opb),
    .res  (eng_res),
    .rem  (eng_rem),
    .done (eng_done)
  );

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= CV_POWER;
      go    <= 1'b0;
    end else begin
      go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_PREP;
            sel   <= CV_POWER;
          end
        end
        S_PREP: begin
          kreg <= 38'(gain_sel) * 38'(kconst);
          den  <= (WW+18)'(ticks_sel) * (WW+18)'(DEN_K);
          if (ticks_sel == '0) begin
            // empty window reads zero
            unique case (sel)
              CV_POWER: results.power_dw       <= '0;
              CV_VOLT:  results.voltage_dv     <= '0;
              CV_CURR:  results.current_ma     <= '0;
              CV_FREQ:  results.power_freq_dhz <= '0;
              default: ;
            endcase
            if (sel == CV_FREQ) begin
              state <= S_EDIV;
              go    <= 1'b1;
            end else begin
              sel <= conv_t'(sel + 2'd1);
            end
          end else begin
            state <= S_SMUL;
            go    <= 1'b1;
          end
        end
        S_SMUL: begin
          if (eng_done) begin
            state <= S_SDIV;
            go    <= 1'b1;
          end
        end
        S_SDIV: begin
          if (eng_done) begin
            unique case (sel)
              CV_POWER: results.power_dw       <= qval[14:0];
              CV_VOLT:  results.voltage_dv     <= qval;
              CV_CURR:  results.current_ma     <= qval;
              CV_FREQ:  results.power_freq_dhz <= qval;
              default: ;
            endcase
            if (sel == CV_FREQ) begin
              state <= S_EDIV;
              go    <= 1'b1;
            end else begin
              sel   <= conv_t'(sel + 2'd1);
              state <= S_PREP;
            end
          end
        end
        S_EDIV: begin
          if (eng_done) begin
            eq    <= eng_res[Q_W-1:0];
            er    <= eng_rem[25:0];
            state <= S_EMUL;
            go    <= 1'b1;
          end
        end
        S_EMUL: begin
          if (eng_done) begin
            ewh   <= eng_res;
            rprod <= 46'(er) * 46'(power_gain);
            state <= S_EDIV2;
            go    <= 1'b1;
          end
        end
        S_EDIV2: begin
          if (eng_done) begin
            results.energy_wh <= (wh_sum > 64'(WH_MAX)) ? WH_MAX : wh_sum[41:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pulse_energy_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_energy_meter
// pulse counter energy meter: windows, lifetime energy, saved-value requests
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_ready       power, mode and timebase counter readings
//  output    out_valid / out_ready     power, voltage, current, freq, energy, save
//  config    cfg_write                 cfg_index, cfg_data (no wait, no read-back)
//
//  one transaction at a time; the accumulate step is registered at accept,
//  then the serial unit runs the conversions: four window values (an empty
//  window skips the serial unit), then watt-hours
//  the next input is taken once the result has moved to the output register
//  reset is synchronous and clears control and accumulator state, not result data; no clearing pass
// ----------------------------------------------------------------------------
`include "pulse_energy_meter_macros.svh"

module pulse_energy_meter
  import pem_pkg::*;
#(
  parameter int ENERGY_WIDTH = ENERGY_WIDTH_DEF,
  parameter int WINDOW_WIDTH = WINDOW_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      power_pulse_count,
  input  logic [15:0]      mode_pulse_count,
  input  logic [15:0]      timebase_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [14:0]      power_dw,
  output logic [15:0]      voltage_dv,
  output logic [15:0]      current_ma,
  output logic [15:0]      power_freq_dhz,
  output logic [41:0]      energy_wh,
  output logic             save_now,
  output logic [47:0]      save_value,
  output logic             current_mode,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // shifted divisor must hold a window divisor moved up by sixteen places
  localparam int DSH_W = (WINDOW_WIDTH + 34 > 64) ? WINDOW_WIDTH + 34 : 64;

  logic                         accept;
  logic                         take;
  logic                         calc_busy;
  logic                         res_valid;
  conv_res_t                    results;
  logic [2:0][WINDOW_WIDTH-1:0] pub_pulses;
  logic [2:0][WINDOW_WIDTH-1:0] pub_ticks;
  logic [ENERGY_WIDTH-1:0]      energy;
  logic [19:0]                  power_gain, voltage_gain, current_gain;
  logic                         acc_save;
  logic [47:0]                  acc_save_value;
  logic                         acc_mode;

  // input transaction only while the sequencer is free
  assign in_ready = !calc_busy;
  assign accept   = in_valid && in_ready;

  // finished result moves into the output register when it is empty or leaving
  assign take = res_valid && (!out_valid || out_ready);

  // deltas, windows, energy total and save decision, all at accept
  pem_accum #(
    .ENERGY_WIDTH (ENERGY_WIDTH),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_accum (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .accept            (accept),
    .power_pulse_count (power_pulse_count),
    .mode_pulse_count  (mode_pulse_count),
    .timebase_count    (timebase_count),
    .pub_pulses        (pub_pulses),
    .pub_ticks         (pub_ticks),
    .energy            (energy),
    .power_gain        (power_gain),
    .voltage_gain      (voltage_gain),
    .current_gain      (current_gain),
    .save_now          (acc_save),
    .save_value        (acc_save_value),
    .mode              (acc_mode)
  );

  // conversions on the shared serial multiply/divide unit
  pem_calc #(
    .ENERGY_WIDTH (ENERGY_WIDTH),
    .WINDOW_WIDTH (WINDOW_WIDTH),
    .DSH_W        (DSH_W)
  ) u_calc (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .take         (take),
    .pub_pulses   (pub_pulses),
    .pub_ticks    (pub_ticks),
    .energy       (energy),
    .power_gain   (power_gain),
    .voltage_gain (voltage_gain),
    .current_gain (current_gain),
    .busy         (calc_busy),
    .res_valid    (res_valid),
    .results      (results)
  );

  // output register; save fields stay put since no accept happens meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid      <= 1'b1;
        power_dw       <= results.power_dw;
        voltage_dv     <= results.voltage_dv;
        current_ma     <= results.current_ma;
        power_freq_dhz <= results.power_freq_dhz;
        energy_wh      <= results.energy_wh;
        save_now       <= acc_save;
        save_value     <= acc_save_value;
        current_mode   <= acc_mode;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `PEM_ASSERT_NXT(a_busy_after_accept, accept, calc_busy, "sequencer idle after accept")
  `PEM_ASSERT_IMP(a_mode_on_accept, !$stable(acc_mode), $past(accept), "mode moved without accept")
  `PEM_ASSERT_IMP(a_save_value_zero, out_valid && !save_now, save_value == 48'd0, "stray save value")

endmodule
`default_nettype wire
